FILE: sv/ivs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared codes and transaction types of the indexed vector store.
// ----------------------------------------------------------------------------
package ivs_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 9;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [WORD_W-1:0]   word_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word_out;
        logic [FILL_W-1:0]   fill_count;
    } rsp_t;

endpackage
`default_nettype wire

FILE: sv/ivs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
interface ivs_req_if;
    logic          valid;
    logic          ready;
    ivs_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/ivs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface ivs_rsp_if;
    logic          valid;
    logic          ready;
    ivs_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/ivs_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_store
// Word memory, fill count and the sequencer that walks the single memory
// port pair to shift entries for insert and erase.
// ----------------------------------------------------------------------------
module ivs_store #(
    parameter int DEPTH = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ivs_pkg::req_t in_req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ivs_pkg::rsp_t      res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ivs_pkg::POS_W) ? CW : ivs_pkg::POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SHUP   = 3'd2;
    localparam logic [2:0] S_INSWR  = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [ivs_pkg::ACTION_W-1:0]   act_reg, act_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [31:0]                    word_reg, word_next;
    logic [AW-1:0]                  dst_reg, dst_next;
    logic [ivs_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [31:0]                    rword_reg, rword_next;

    logic [31:0]   mem_array [DEPTH];
    logic [31:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic          accept;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic          pos_ok;
    logic          full;
    logic          empty;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] count_a;
    logic [AW-1:0] last_a;
    logic [AW-1:0] pos_in_a;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_array[mem_raddr];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign pos_x     = XW'(in_req.position);
    assign count_x   = XW'(count_reg);
    assign pos_ok    = pos_x < count_x;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - CW'(1);
    assign count_a   = AW'(count_reg);
    assign last_a    = AW'(count_m1);
    assign pos_in_a  = AW'(pos_x);

    assign res_valid           = (state_reg == S_DONE);
    assign res.status          = status_reg;
    assign res.word_out        = rword_reg;
    assign res.fill_count      = ivs_pkg::FILL_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        act_next    = act_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        dst_next    = dst_reg;
        status_next = status_reg;
        rword_next  = rword_reg;
        mem_we      = 1'b0;
        mem_waddr   = dst_reg;
        mem_wdata   = rdata_reg;
        mem_re      = 1'b0;
        mem_raddr   = last_a;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next    = in_req.action;
                    pos_next    = pos_in_a;
                    word_next   = in_req.word_in;
                    status_next = ivs_pkg::ST_OK;
                    rword_next  = '0;
                    state_next  = S_DONE;
                    case (in_req.action)
                        ivs_pkg::ACT_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ivs_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_a;
                                mem_wdata  = in_req.word_in;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ivs_pkg::ACT_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = ivs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                                mem_re     = 1'b1;
                                mem_raddr  = last_a;
                                state_next = S_RDWAIT;
                            end
                        end
                        ivs_pkg::ACT_READ:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ivs_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_in_a;
                                state_next = S_RDWAIT;
                            end
                        end
                        ivs_pkg::ACT_INSERT:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ivs_pkg::ST_BADPOS;
                            end
                            else if (full)
                            begin
                                status_next = ivs_pkg::ST_FULL;
                            end
                            else
                            begin
                                // walk down from the top, one word per cycle
                                mem_re     = 1'b1;
                                mem_raddr  = last_a;
                                dst_next   = count_a;
                                state_next = S_SHUP;
                            end
                        end
                        ivs_pkg::ACT_ERASE:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ivs_pkg::ST_BADPOS;
                            end
                            else if (pos_in_a == last_a)
                            begin
                                count_next = count_m1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_in_a + AW'(1);
                                dst_next   = pos_in_a;
                                state_next = S_SHDN;
                            end
                        end
                        ivs_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ivs_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                rword_next = rdata_reg;
                state_next = S_DONE;
            end
            S_SHUP:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rdata_reg;
                if ((dst_reg - AW'(1)) == pos_reg)
                begin
                    state_next = S_INSWR;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = dst_reg - AW'(2);
                    dst_next  = dst_reg - AW'(1);
                end
            end
            S_INSWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = word_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_SHDN:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rdata_reg;
                if ((dst_reg + AW'(1)) == last_a)
                begin
                    count_next = count_m1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = dst_reg + AW'(2);
                    dst_next  = dst_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        rword_reg  <= rword_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not leave idle");

    a_shift_up_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUP) |-> (dst_reg > pos_reg))
        else $error("insert shift ran past the insert position");

    a_empty_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ivs_pkg::ST_EMPTY)) |-> (act_reg == ivs_pkg::ACT_REMOVE))
        else $error("empty status on a request other than remove");

    a_count_hold_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SHUP) && $past(state_reg == S_SHUP)) |-> $stable(count_reg))
        else $error("fill count moved during insert shift");
`endif

endmodule
`default_nettype wire

FILE: sv/ivs_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_out
// Output register: holds one result so the sequencer can go idle while the
// receiver stalls.
// ----------------------------------------------------------------------------
module ivs_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    output logic               res_ready,
    input  wire ivs_pkg::rsp_t res,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ivs_pkg::rsp_t      out_data
);

    logic          valid_reg;
    ivs_pkg::rsp_t data_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule
`default_nettype wire

FILE: sv/indexed_vector_store_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_vector_store_core
// Packed ordered store of 32-bit words with append, remove, read, insert,
// erase and clear; one result transaction per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req carries action, position and word_in; rsp carries status, word_out
//   and the fill count after the request. Both are valid/ready channels.
//   One request is in work at a time; req.ready is high while the sequencer
//   is idle.
//   Append, clear, unused codes and every error answer straight from idle;
//   read and remove first wait for the registered memory read; insert and
//   erase first shift the words above the position through the single
//   memory port pair, one word at a time.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, and a stalled rsp holds the next result in the
//   sequencer until the register drains.
//   Reset empties the store (fill count zero) at once; no clearing pass is
//   run and the words themselves are undefined until written.
// ----------------------------------------------------------------------------
module indexed_vector_store_core #(
    parameter int DEPTH = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ivs_req_if.sink   req,
    ivs_rsp_if.source rsp
);

    logic          res_valid;
    logic          res_ready;
    ivs_pkg::rsp_t res;

    ivs_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_req    (req.payload),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ivs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.payload)
    );

endmodule
`default_nettype wire

FILE: tb/sv/ivs_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ivs_result_checker
// Watches the request and result channels of the indexed vector store, keeps
// a shadow copy of the stored words and the fill count, and compares every
// result transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module ivs_result_checker #(
    parameter int DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    ivs_req_if   req,
    ivs_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    logic [ivs_pkg::WORD_W-1:0] shadow_words [DEPTH];
    int unsigned                shadow_count;
    ivs_pkg::rsp_t              pending_results [$];

    // Applies one request to the shadow store and returns the result it causes.
    function automatic ivs_pkg::rsp_t apply_request(input ivs_pkg::req_t r);
        ivs_pkg::rsp_t res;
        int unsigned   k;
        res.status   = ivs_pkg::ST_OK;
        res.word_out = '0;
        case (r.action)
            ivs_pkg::ACT_APPEND:
            begin
                if (shadow_count >= DEPTH)
                    res.status = ivs_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = r.word_in;
                    shadow_count++;
                end
            end
            ivs_pkg::ACT_REMOVE:
            begin
                if (shadow_count == 0)
                    res.status = ivs_pkg::ST_EMPTY;
                else
                begin
                    shadow_count--;
                    res.word_out = shadow_words[shadow_count];
                end
            end
            ivs_pkg::ACT_READ:
            begin
                if (r.position >= shadow_count)
                    res.status = ivs_pkg::ST_BADPOS;
                else
                    res.word_out = shadow_words[r.position];
            end
            ivs_pkg::ACT_INSERT:
            begin
                // position is checked before fullness
                if (r.position >= shadow_count)
                    res.status = ivs_pkg::ST_BADPOS;
                else if (shadow_count >= DEPTH)
                    res.status = ivs_pkg::ST_FULL;
                else
                begin
                    for (k = shadow_count; k > r.position; k--)
                        shadow_words[k] = shadow_words[k - 1];
                    shadow_words[r.position] = r.word_in;
                    shadow_count++;
                end
            end
            ivs_pkg::ACT_ERASE:
            begin
                if (r.position >= shadow_count)
                    res.status = ivs_pkg::ST_BADPOS;
                else
                begin
                    for (k = r.position; k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k + 1];
                    shadow_count--;
                end
            end
            ivs_pkg::ACT_CLEAR:
                shadow_count = 0;   // words stay as they are
            default:
                ;                   // spare codes change nothing
        endcase
        res.fill_count = ivs_pkg::FILL_W'(shadow_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ivs_pkg::rsp_t got;
        ivs_pkg::rsp_t want;
        ivs_pkg::rsp_t predicted;
        if (!rst_n)
        begin
            pending_results.delete();
            shadow_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // a result trails its request through the sequencer and output register, so check first
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d word_out %08h fill_count %0d",
                           got.status, got.word_out, got.fill_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatches++;
                    end
                    if (got.word_out !== want.word_out)
                    begin
                        $error("word_out mismatch: expected %08h, actual %08h",
                               want.word_out, got.word_out);
                        mismatches++;
                    end
                    if (got.fill_count !== want.fill_count)
                    begin
                        $error("fill_count mismatch: expected %0d, actual %0d",
                               want.fill_count, got.fill_count);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                predicted       = apply_request(req.payload);
                pending_results = {pending_results, predicted};
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: tb/sv/indexed_vector_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_vector_store_core_tb
// Drives request transactions into the vector store with random gaps and
// result back-pressure: a short directed pass over the corner cases, a fill
// to full depth, then random sequences that mostly use valid positions.
// ----------------------------------------------------------------------------
module indexed_vector_store_core_tb;

    localparam int DEPTH        = 256;
    localparam int TOTAL_ITEMS  = 850;
    localparam int QUIET_ITEMS  = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    // spare action codes, answered with no change
    localparam logic [ivs_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ivs_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int          mismatches;
    int          outstanding;
    bit          gaps_on;
    bit          stalls_on;
    bit          hold_off_req;
    int unsigned level;
    int          items_sent;

    ivs_req_if req_ch ();
    ivs_rsp_if rsp_ch ();

    indexed_vector_store_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ivs_result_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("indexed_vector_store_core test failed");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [ivs_pkg::ACTION_W-1:0] action,
                                input logic [ivs_pkg::POS_W-1:0]    pos,
                                input logic [ivs_pkg::WORD_W-1:0]   word);
        ivs_pkg::req_t r;
        r.action   = action;
        r.position = pos;
        r.word_in  = word;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        // rough fill level, only to steer the stimulus
        case (action)
            ivs_pkg::ACT_APPEND: if (level < DEPTH) level++;
            ivs_pkg::ACT_REMOVE: if (level > 0) level--;
            ivs_pkg::ACT_INSERT: if (pos < level && level < DEPTH) level++;
            ivs_pkg::ACT_ERASE:  if (pos < level) level--;
            ivs_pkg::ACT_CLEAR:  level = 0;
            default:             ;
        endcase
        @(negedge clk);
    endtask

    // Mostly a position inside the filled range, now and then any position.
    function automatic logic [ivs_pkg::POS_W-1:0] pick_pos();
        if (level == 0 || $urandom_range(0, 7) == 0)
            return ivs_pkg::POS_W'($urandom_range(0, 255));
        return ivs_pkg::POS_W'($urandom_range(0, level - 1));
    endfunction

    task automatic fill_to_top();
        while (level < DEPTH)
            send_request(ivs_pkg::ACT_APPEND, pick_pos(), $urandom());
        send_request(ivs_pkg::ACT_APPEND, pick_pos(), $urandom());      // full
        send_request(ivs_pkg::ACT_INSERT, pick_pos(), $urandom());      // full
        send_request(ivs_pkg::ACT_INSERT, 8'hFF, 32'hFFFF_FFFF);        // full
        send_request(ivs_pkg::ACT_READ,   8'hFF, $urandom());
        send_request(ivs_pkg::ACT_ERASE,  8'hFF, $urandom());
        send_request(ivs_pkg::ACT_INSERT, 8'h00, $urandom());           // longest shift
        send_request(ivs_pkg::ACT_ERASE,  8'h00, $urandom());           // longest shift
    endtask

    initial
    begin
        bit hold_done;
        bit filled_once;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        hold_done      = 1'b0;
        filled_once    = 1'b0;
        level          = 0;
        items_sent     = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corner cases
        send_request(ivs_pkg::ACT_REMOVE, 8'h00, 32'h0000_0000);   // empty store
        send_request(ivs_pkg::ACT_READ,   8'h00, 32'hFFFF_FFFF);   // nothing stored
        send_request(ivs_pkg::ACT_INSERT, 8'h00, 32'hDEAD_BEEF);   // insert into empty
        send_request(ivs_pkg::ACT_ERASE,  8'h00, 32'h0000_0000);   // erase on empty
        send_request(ivs_pkg::ACT_APPEND, 8'hFF, 32'h0000_0000);
        send_request(ivs_pkg::ACT_APPEND, 8'h00, 32'hFFFF_FFFF);
        send_request(ivs_pkg::ACT_APPEND, 8'h55, 32'hA5A5_5A5A);
        send_request(ivs_pkg::ACT_READ,   8'h00, 32'h0000_0000);
        send_request(ivs_pkg::ACT_READ,   8'h02, 32'h0000_0000);
        send_request(ivs_pkg::ACT_READ,   8'h03, 32'h0000_0000);   // at the count
        send_request(ivs_pkg::ACT_READ,   8'hFF, 32'h0000_0000);
        send_request(ivs_pkg::ACT_INSERT, 8'h00, 32'h1234_5678);
        send_request(ivs_pkg::ACT_INSERT, 8'h02, 32'h8765_4321);
        send_request(ivs_pkg::ACT_INSERT, 8'h05, 32'h0BAD_F00D);   // at the end: invalid
        send_request(ivs_pkg::ACT_ERASE,  8'h00, 32'h0000_0000);
        send_request(ivs_pkg::ACT_ERASE,  8'h03, 32'h0000_0000);   // last word
        send_request(ivs_pkg::ACT_ERASE,  8'hFF, 32'h0000_0000);
        send_request(ivs_pkg::ACT_REMOVE, 8'hAA, 32'hFFFF_FFFF);
        send_request(ACT_SPARE_6, 8'h01, 32'hFFFF_FFFF);
        send_request(ACT_SPARE_7, 8'hFE, 32'h0000_0000);
        send_request(ivs_pkg::ACT_READ,   8'h01, 32'h0000_0000);
        send_request(ivs_pkg::ACT_CLEAR,  8'h7F, 32'hFFFF_FFFF);
        send_request(ivs_pkg::ACT_READ,   8'h00, 32'h0000_0000);   // after clear
        send_request(ivs_pkg::ACT_REMOVE, 8'h00, 32'h0000_0000);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent > TOTAL_ITEMS - QUIET_ITEMS)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                gaps_on   = $urandom_range(0, 1);
                stalls_on = $urandom_range(0, 1);
            end
            if (!hold_done && items_sent >= 400)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!filled_once)
            begin
                filled_once = 1'b1;
                fill_to_top();
            end
            else
            begin
                case ($urandom_range(0, 39))
                    0:
                        // a full pass only while it still fits in the run
                        if (items_sent + DEPTH + 8 <= TOTAL_ITEMS)
                            fill_to_top();
                    1, 2, 3, 4:
                        repeat ($urandom_range(1, 40))
                            send_request(ivs_pkg::ACT_APPEND, pick_pos(), $urandom());
                    5, 6, 7:
                        repeat ($urandom_range(1, 40))
                            send_request(ivs_pkg::ACT_REMOVE, pick_pos(), $urandom());
                    8, 9, 10, 11:
                        // noise: any code, any position
                        repeat ($urandom_range(1, 8))
                            send_request(ivs_pkg::ACTION_W'($urandom_range(0, 7)),
                                         ivs_pkg::POS_W'($urandom_range(0, 255)),
                                         $urandom());
                    12:
                        send_request(ivs_pkg::ACT_CLEAR, pick_pos(), $urandom());
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0: send_request(ivs_pkg::ACT_APPEND, pick_pos(), $urandom());
                            1: send_request(ivs_pkg::ACT_REMOVE, pick_pos(), $urandom());
                            2: send_request(ivs_pkg::ACT_READ,   pick_pos(), $urandom());
                            3: send_request(ivs_pkg::ACT_INSERT, pick_pos(), $urandom());
                            default:
                                send_request(ivs_pkg::ACT_ERASE, pick_pos(), $urandom());
                        endcase
                    end
                endcase
            end
        end
        req_ch.valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("indexed_vector_store_core test passed");
        else
            $display("indexed_vector_store_core test failed");
        $finish;
    end

endmodule

FILE: files.f
sv/ivs_pkg.sv
sv/ivs_req_if.sv
sv/ivs_rsp_if.sv
sv/ivs_store.sv
sv/ivs_out.sv
sv/indexed_vector_store_core.sv
tb/sv/ivs_result_checker.sv
tb/sv/indexed_vector_store_core_tb.sv
